[rtl/core/pfps_pkg.sv]
// ============================================================================
// pfps_pkg: shared types and constants of the packed FFT power spectrum
// Item structs for both channels, configuration register indexes, queue
// entry kinds and the fixed-point constants of the log unit.
// ============================================================================
package pfps_pkg;

	// Field widths of the two channels.
	localparam int IDX_W   = 8;
	localparam int PART_W  = 24;
	localparam int BIN_W   = 9;
	localparam int VALUE_W = 48;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_POWER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_LOG   = 8'd1;

	// Kinds of queued items: an ordinary pair, or the DC/Nyquist pair.
	localparam logic KIND_SINGLE = 1'b0;
	localparam logic KIND_DUAL   = 1'b1;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Log unit: word width, log2 fraction bits, ln2 scale and result width.
	localparam int LOG_W   = 64;
	localparam int FRAC_W  = 32;
	localparam int LN2_W   = 24;
	localparam int Q_FRAC  = 16;
	localparam int LN_W    = 23;
	localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;

	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	typedef struct packed {
		logic [IDX_W-1:0]         pair_index;
		logic signed [PART_W-1:0] real_part;
		logic signed [PART_W-1:0] imag_part;
	} pair_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin_index;
		logic [VALUE_W-1:0] bin_value;
		logic               last_of_item;
	} bin_t;

	typedef struct packed {
		logic keep_power;
		logic take_log;
	} cfg_t;

endpackage

[rtl/core/pfps_front.sv]
// ============================================================================
// pfps_front: input side of the packed FFT power spectrum
// Takes pairs, forms the magnitudes of both parts, drops pairs beyond the
// half spectrum and queues the rest with their kind for the back side.
// ============================================================================
module pfps_front #(
	parameter int FFT_SIZE     = 512,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  pfps_pkg::pair_t               pair,
	output logic                          q_valid,
	output logic                          q_kind,
	output logic [pfps_pkg::IDX_W-1:0]    q_bin,
	output logic [SAMPLE_WIDTH-1:0]       q_mag_a,
	output logic [SAMPLE_WIDTH-1:0]       q_mag_b,
	input  logic                          q_pop
);
	import pfps_pkg::*;

	localparam int unsigned HALF_BINS = FFT_SIZE / 2;
	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [SAMPLE_WIDTH-1:0] raw_re;
	logic [SAMPLE_WIDTH-1:0] raw_im;
	logic [SAMPLE_WIDTH-1:0] mag_re;
	logic [SAMPLE_WIDTH-1:0] mag_im;
	logic                    in_range;
	logic                    push;

	logic                    kind_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]        bin_q  [QUEUE_DEPTH];
	logic [SAMPLE_WIDTH-1:0] mag_a_q [QUEUE_DEPTH];
	logic [SAMPLE_WIDTH-1:0] mag_b_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]       wr_ptr_q;
	logic [QIDX_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	// Part: low SAMPLE_WIDTH bits, two's complement, or field zero-extended.
	generate
		if (SAMPLE_WIDTH <= PART_W) begin : g_narrow
			assign raw_re = pair.real_part[SAMPLE_WIDTH-1:0];
			assign raw_im = pair.imag_part[SAMPLE_WIDTH-1:0];
		end else begin : g_wide
			assign raw_re = {{(SAMPLE_WIDTH-PART_W){1'b0}}, pair.real_part};
			assign raw_im = {{(SAMPLE_WIDTH-PART_W){1'b0}}, pair.imag_part};
		end
	endgenerate

	// The most negative value maps onto itself, read as unsigned.
	assign mag_re = raw_re[SAMPLE_WIDTH-1] ? (~raw_re + SAMPLE_WIDTH'(1)) : raw_re;
	assign mag_im = raw_im[SAMPLE_WIDTH-1] ? (~raw_im + SAMPLE_WIDTH'(1)) : raw_im;

	assign in_range   = (32'(pair.pair_index) < HALF_BINS);
	assign pair_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = pair_valid && !pair_stall && in_range;

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]  <= (pair.pair_index == '0) ? KIND_DUAL : KIND_SINGLE;
			bin_q[wr_ptr_q]   <= pair.pair_index;
			mag_a_q[wr_ptr_q] <= mag_re;
			mag_b_q[wr_ptr_q] <= mag_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QIDX_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QIDX_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	assign q_valid = (count_q != '0);
	assign q_kind  = kind_q[rd_ptr_q];
	assign q_bin   = bin_q[rd_ptr_q];
	assign q_mag_a = mag_a_q[rd_ptr_q];
	assign q_mag_b = mag_b_q[rd_ptr_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
		else $error("queue count did not drop on a pop");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (count_q != '0))
		else $error("pop from an empty queue");

endmodule

[rtl/core/pfps_isqrt.sv]
// ============================================================================
// pfps_isqrt: pipelined floor integer square root
// One result bit per stage by restoring compare and subtract; a tag rides
// alongside each value.
// ============================================================================
module pfps_isqrt #(
	parameter int RW    = 24,
	parameter int TAG_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [2*RW-1:0]   in_val,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_vld,
	output logic [RW-1:0]     out_root,
	output logic [TAG_W-1:0]  out_tag
);
	localparam int PW = 2 * RW;

	logic             vld_s [1:RW];
	logic [PW-1:0]    rem_s [1:RW];
	logic [PW-1:0]    res_s [1:RW];
	logic [TAG_W-1:0] tag_s [1:RW];

	generate
		for (genvar i = 0; i < RW; i++) begin : g_step
			localparam logic [PW-1:0] BIT = PW'(1) << (2 * (RW - 1 - i));

			logic             cur_vld;
			logic [PW-1:0]    cur_rem;
			logic [PW-1:0]    cur_res;
			logic [TAG_W-1:0] cur_tag;
			logic [PW:0]      trial;
			logic [PW-1:0]    nxt_rem;
			logic [PW-1:0]    nxt_res;

			if (i == 0) begin : g_src
				assign cur_vld = in_vld;
				assign cur_rem = in_val;
				assign cur_res = '0;
				assign cur_tag = in_tag;
			end else begin : g_src
				assign cur_vld = vld_s[i];
				assign cur_rem = rem_s[i];
				assign cur_res = res_s[i];
				assign cur_tag = tag_s[i];
			end

			always_comb begin
				trial = {1'b0, cur_res} + {1'b0, BIT};
				if ({1'b0, cur_rem} >= trial) begin
					nxt_rem = cur_rem - trial[PW-1:0];
					nxt_res = (cur_res >> 1) + BIT;
				end else begin
					nxt_rem = cur_rem;
					nxt_res = cur_res >> 1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i+1] <= 1'b0;
				end else if (en) begin
					vld_s[i+1] <= cur_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= nxt_rem;
					res_s[i+1] <= nxt_res;
					tag_s[i+1] <= cur_tag;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[RW];
	assign out_root = res_s[RW][RW-1:0];
	assign out_tag  = tag_s[RW];

endmodule

[rtl/core/pfps_ln.sv]
// ============================================================================
// pfps_ln: pipelined natural log in unsigned Q7.16
// Normalizes over six shift stages, forms 32 bits of log2 fraction by one
// squaring per stage, then scales by ln2 and rounds to nearest.
// ============================================================================
module pfps_ln #(
	parameter int TAG_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [pfps_pkg::LOG_W-1:0]  in_val,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_vld,
	output logic [pfps_pkg::LN_W-1:0]   out_ln,
	output logic [TAG_W-1:0]            out_tag
);
	import pfps_pkg::*;

	localparam int NORM_ST = $clog2(LOG_W);
	localparam int LZ_W    = NORM_ST;
	localparam int SQ_ST   = FRAC_W;
	localparam int MUL_ST  = NORM_ST + SQ_ST;
	localparam int LAT     = MUL_ST + 2;
	localparam int PF_W    = FRAC_W + LN2_W;
	localparam int PE_W    = LZ_W + LN2_W;
	localparam int RND_SH  = FRAC_W + LN2_W - Q_FRAC;
	localparam int SUM_W   = RND_SH + LN_W;
	localparam logic [SUM_W-1:0] RND_ONE = SUM_W'(1) << (RND_SH - 1);

	logic             vld_s   [1:LAT];
	logic [TAG_W-1:0] tag_s   [1:LAT];
	logic             small_s [1:LAT-1];

	logic [LOG_W-1:0]  nw_s   [1:NORM_ST];
	logic [LZ_W-1:0]   lz_s   [1:NORM_ST];
	logic [FRAC_W-1:0] x_s    [1:SQ_ST];
	logic [FRAC_W-1:0] frac_s [1:SQ_ST];
	logic [LZ_W-1:0]   e_s    [1:SQ_ST];
	logic [PF_W-1:0]   pf_s;
	logic [PE_W-1:0]   pe_s;
	logic [LN_W-1:0]   ln_s;
	logic [SUM_W-1:0]  sum;

	// Valid, tag and the "value below two" flag ride along every stage.
	generate
		for (genvar k = 0; k < LAT; k++) begin : g_side
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[1] <= 1'b0;
					end else if (en) begin
						vld_s[1] <= in_vld;
					end
				end
				always_ff @(posedge clk) begin
					if (en) begin
						tag_s[1]   <= in_tag;
						small_s[1] <= (in_val < LOG_W'(2));
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[k+1] <= 1'b0;
					end else if (en) begin
						vld_s[k+1] <= vld_s[k];
					end
				end
				always_ff @(posedge clk) begin
					if (en) begin
						tag_s[k+1] <= tag_s[k];
					end
				end
				if (k < LAT - 1) begin : g_small
					always_ff @(posedge clk) begin
						if (en) begin
							small_s[k+1] <= small_s[k];
						end
					end
				end
			end
		end
	endgenerate

	// Leading-zero normalization, halving the probed width each stage.
	generate
		for (genvar k = 0; k < NORM_ST; k++) begin : g_norm
			localparam int SH = (LOG_W / 2) >> k;

			logic [LOG_W-1:0] cur_w;
			logic [LZ_W-1:0]  cur_lz;

			if (k == 0) begin : g_src
				assign cur_w  = in_val;
				assign cur_lz = '0;
			end else begin : g_src
				assign cur_w  = nw_s[k];
				assign cur_lz = lz_s[k];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (cur_w[LOG_W-1 -: SH] == '0) begin
						nw_s[k+1] <= cur_w << SH;
						lz_s[k+1] <= cur_lz + LZ_W'(SH);
					end else begin
						nw_s[k+1] <= cur_w;
						lz_s[k+1] <= cur_lz;
					end
				end
			end
		end
	endgenerate

	// One log2 fraction bit per stage: square the Q1.31 mantissa, renormalize.
	generate
		for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
			logic [FRAC_W-1:0]   cur_x;
			logic [FRAC_W-1:0]   cur_frac;
			logic [LZ_W-1:0]     cur_e;
			logic [2*FRAC_W-1:0] sq;
			logic [FRAC_W:0]     t;

			if (j == 0) begin : g_src
				assign cur_x    = nw_s[NORM_ST][LOG_W-1 -: FRAC_W];
				assign cur_frac = '0;
				assign cur_e    = LZ_W'(LOG_W - 1) - lz_s[NORM_ST];
			end else begin : g_src
				assign cur_x    = x_s[j];
				assign cur_frac = frac_s[j];
				assign cur_e    = e_s[j];
			end

			assign sq = (2*FRAC_W)'(cur_x) * (2*FRAC_W)'(cur_x);
			assign t  = sq[2*FRAC_W-1:FRAC_W-1];

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[j+1]    <= t[FRAC_W] ? t[FRAC_W:1] : t[FRAC_W-1:0];
					frac_s[j+1] <= {cur_frac[FRAC_W-2:0], t[FRAC_W]};
					e_s[j+1]    <= cur_e;
				end
			end
		end
	endgenerate

	// The exponent and fraction products are kept apart and joined in the
	// rounding add.
	always_ff @(posedge clk) begin
		if (en) begin
			pf_s <= PF_W'(frac_s[SQ_ST]) * PF_W'(LN2_Q24);
			pe_s <= PE_W'(e_s[SQ_ST]) * PE_W'(LN2_Q24);
		end
	end

	assign sum = SUM_W'({pe_s, {FRAC_W{1'b0}}}) + SUM_W'(pf_s) + RND_ONE;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s <= small_s[LAT-1] ? '0 : sum[RND_SH +: LN_W];
		end
	end

	assign out_vld = vld_s[LAT];
	assign out_tag = tag_s[LAT];
	assign out_ln  = ln_s;

endmodule

[rtl/core/pfps_back.sv]
// ============================================================================
// pfps_back: result side of the packed FFT power spectrum
// Issues one result per cycle from the queue head (two for the DC/Nyquist
// pair), squares and sums, then runs root and log units and the output
// register. An output stall freezes the whole pipeline.
// ============================================================================
module pfps_back #(
	parameter int FFT_SIZE     = 512,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfps_pkg::cfg_t              cfg,
	input  logic                        q_valid,
	input  logic                        q_kind,
	input  logic [pfps_pkg::IDX_W-1:0]  q_bin,
	input  logic [SAMPLE_WIDTH-1:0]     q_mag_a,
	input  logic [SAMPLE_WIDTH-1:0]     q_mag_b,
	output logic                        q_pop,
	output logic                        bin_valid,
	input  logic                        bin_stall,
	output pfps_pkg::bin_t              bin
);
	import pfps_pkg::*;

	localparam int PW     = 2 * SAMPLE_WIDTH;
	localparam int SQ_TAG = BIN_W + 1 + PW;
	localparam int LN_TAG = BIN_W + 1 + VALUE_W;
	localparam logic [BIN_W-1:0] NYQ_BIN = BIN_W'(FFT_SIZE / 2);

	logic                    en;
	logic                    first;
	logic                    second;
	logic                    phase_q;
	logic [SAMPLE_WIDTH-1:0] iss_a;
	logic [SAMPLE_WIDTH-1:0] iss_b;
	logic [BIN_W-1:0]        iss_bin;
	logic                    iss_last;

	logic             vld_s1;
	logic [PW-1:0]    sqa_s1;
	logic [PW-1:0]    sqb_s1;
	logic [BIN_W-1:0] bin_s1;
	logic             last_s1;
	logic             vld_s2;
	logic [PW-1:0]    pow_s2;
	logic [BIN_W-1:0] bin_s2;
	logic             last_s2;

	logic                    rt_vld;
	logic [SAMPLE_WIDTH-1:0] rt_root;
	logic [SQ_TAG-1:0]       rt_tag;
	logic [BIN_W-1:0]        rt_bin;
	logic                    rt_last;
	logic [PW-1:0]           rt_pow;
	logic [PW-1:0]           mag_v;
	logic [LOG_W-1:0]        mag_w;
	logic [VALUE_W-1:0]      mag_sat;

	logic               ln_vld;
	logic [LN_W-1:0]    ln_val;
	logic [LN_TAG-1:0]  ln_tag;
	logic [BIN_W-1:0]   ln_bin;
	logic               ln_last;
	logic [VALUE_W-1:0] ln_plain;

	logic out_vld_q;
	bin_t out_q;

	assign en = !(out_vld_q && bin_stall);

	// The DC/Nyquist entry stays at the head until its DC and its Nyquist half have both been issued.
	always_comb begin
		first    = (q_kind == KIND_DUAL) && !phase_q;
		second   = (q_kind == KIND_DUAL) && phase_q;
		iss_a    = q_mag_a;
		iss_b    = q_mag_b;
		iss_bin  = BIN_W'(q_bin);
		iss_last = 1'b1;
		if (first) begin
			iss_b    = '0;
			iss_bin  = '0;
			iss_last = 1'b0;
		end else if (second) begin
			iss_a   = q_mag_b;
			iss_b   = '0;
			iss_bin = NYQ_BIN;
		end
	end

	assign q_pop = en && q_valid && !first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else if (en) begin
			if (q_valid) begin
				phase_q <= first;
			end
			vld_s1 <= q_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1  <= PW'(iss_a) * PW'(iss_a);
			sqb_s1  <= PW'(iss_b) * PW'(iss_b);
			bin_s1  <= iss_bin;
			last_s1 <= iss_last;
			pow_s2  <= sqa_s1 + sqb_s1;
			bin_s2  <= bin_s1;
			last_s2 <= last_s1;
		end
	end

	pfps_isqrt #(
		.RW    (SAMPLE_WIDTH),
		.TAG_W (SQ_TAG)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_val   (pow_s2),
		.in_tag   ({bin_s2, last_s2, pow_s2}),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_tag  (rt_tag)
	);

	assign {rt_bin, rt_last, rt_pow} = rt_tag;

	// The log sees the unsaturated value; the plain result saturates.
	assign mag_v   = cfg.keep_power ? rt_pow : PW'(rt_root);
	assign mag_w   = LOG_W'(mag_v);
	assign mag_sat = (|mag_w[LOG_W-1:VALUE_W]) ? VALUE_MAX : mag_w[VALUE_W-1:0];

	pfps_ln #(
		.TAG_W (LN_TAG)
	) u_ln (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (rt_vld),
		.in_val  (mag_w),
		.in_tag  ({rt_bin, rt_last, mag_sat}),
		.out_vld (ln_vld),
		.out_ln  (ln_val),
		.out_tag (ln_tag)
	);

	assign {ln_bin, ln_last, ln_plain} = ln_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ln_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.bin_index    <= ln_bin;
			out_q.last_of_item <= ln_last;
			out_q.bin_value    <= cfg.take_log ? VALUE_W'(ln_val) : ln_plain;
		end
	end

	assign bin_valid = out_vld_q;
	assign bin       = out_q;

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_valid && (q_kind == KIND_DUAL)))
		else $error("second half pending without a dual entry at the head");

	a_second_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(en && q_valid && phase_q) |-> q_pop)
		else $error("Nyquist half issued without popping the queue");

	a_first_is_dc: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_valid && !bin.last_of_item) |-> (bin.bin_index == '0))
		else $error("non-final result that is not the DC bin");

endmodule

[rtl/core/packed_fft_power_spectrum.sv]
// ============================================================================
// packed_fft_power_spectrum: power spectrum from a packed real FFT frame
// Turns each pair of a packed real-FFT frame into spectrum bins: power,
// floor root magnitude, or natural log in unsigned Q7.16.
// ============================================================================
//
//  Channel  Handshake              Item          Direction
//  -------  ---------------------  ------------  ---------
//  pair     pair_valid/pair_stall  pfps_pkg::pair_t  in
//  bin      bin_valid/bin_stall    pfps_pkg::bin_t   out
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data  in
//
// One pair item is taken per clock while pair_stall is low. Pair 0 (DC and
// Nyquist) yields two bin items, one after the other, and every other pair
// one, so a frame of FFT_SIZE/2 pairs leaves as FFT_SIZE/2+1 bin items; a
// four-entry queue between the front and the back absorbs the extra item.
// From the queue a bin item passes through the square register, the sum
// register, SAMPLE_WIDTH root stages, forty log stages and the output
// register. Pairs at or beyond FFT_SIZE/2 are taken and dropped.
// Reset sets keep_power to 1 and take_log to 0 and empties every stage.
// bin_stall, while a bin is valid, freezes the whole back pipeline; pairs
// keep being taken until four wait in the queue, then pair_stall rises.
//
// The log unit takes ln(max(v,1)) of the power or, with keep_power low, of
// its floor square root. The plain power saturates at 2^48-1, which only a
// SAMPLE_WIDTH above 24 can reach.
module packed_fft_power_spectrum #(
	parameter int FFT_SIZE     = 512,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pair_valid,
	output logic                             pair_stall,
	input  pfps_pkg::pair_t                  pair,
	output logic                             bin_valid,
	input  logic                             bin_stall,
	output pfps_pkg::bin_t                   bin,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pfps_pkg::*;

	cfg_t                    cfg_q;
	logic                    q_valid;
	logic                    q_kind;
	logic [IDX_W-1:0]        q_bin;
	logic [SAMPLE_WIDTH-1:0] q_mag_a;
	logic [SAMPLE_WIDTH-1:0] q_mag_b;
	logic                    q_pop;

	// Configuration is always accepted. Only the low data bit is kept, and
	// an index beyond the register list writes nothing.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_power <= 1'b1;
			cfg_q.take_log   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEEP_POWER: cfg_q.keep_power <= cfg_data[0];
				CFG_TAKE_LOG:   cfg_q.take_log   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: magnitudes of both parts, range check, kind and queue.
	pfps_front #(
		.FFT_SIZE     (FFT_SIZE),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.q_valid    (q_valid),
		.q_kind     (q_kind),
		.q_bin      (q_bin),
		.q_mag_a    (q_mag_a),
		.q_mag_b    (q_mag_b),
		.q_pop      (q_pop)
	);

	// Back: one bin per cycle, unless an output stall holds it, through squaring, root, log and output.
	pfps_back #(
		.FFT_SIZE     (FFT_SIZE),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_kind    (q_kind),
		.q_bin     (q_bin),
		.q_mag_a   (q_mag_a),
		.q_mag_b   (q_mag_b),
		.q_pop     (q_pop),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin       (bin)
	);

endmodule
